// ===== rtl/bbl_pkg.sv =====
// ----------------------------------------------------------------------------
// bbl_pkg
// Shared types and constants of the bounded byte list engine: request and
// response items, operation and status codes, controller states and the
// command that the controller broadcasts to the row of list cells.
// ----------------------------------------------------------------------------
package bbl_pkg;

  // Default list capacity
  localparam int unsigned BBL_CAPACITY = 16;

  // Width of the count fields of a response item
  localparam int unsigned BBL_CNT_OUT_W = 5;

  // Request operation codes
  typedef enum logic [2:0] {
    OP_INS_FIRST    = 3'd0,
    OP_INS_MIDDLE   = 3'd1,
    OP_INS_LAST     = 3'd2,
    OP_DEL_FIRST    = 3'd3,
    OP_DEL_ALL      = 3'd4,
    OP_DEL_LAST     = 3'd5,
    OP_CLEAR        = 3'd6,
    OP_QUERY        = 3'd7
  } bbl_op_e;

  // Response status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } bbl_status_e;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } bbl_state_e;

  // Command broadcast to every list cell
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } bbl_cell_cmd_e;

  // Request item
  typedef struct packed {
    bbl_op_e    req_type;
    logic [7:0] value;
  } bbl_req_t;

  // Response item
  typedef struct packed {
    bbl_status_e              status;
    logic                     found;
    logic [7:0]               located_value;
    logic [BBL_CNT_OUT_W-1:0] removed_count;
    logic [BBL_CNT_OUT_W-1:0] item_count;
  } bbl_rsp_t;

endpackage

// ===== rtl/bounded_byte_list_engine.sv =====
// ----------------------------------------------------------------------------
// bounded_byte_list_engine
// Ordered list of up to CAPACITY bytes held in a row of cells, with a
// controller that runs insert, delete, clear and query requests.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. For most requests the
// accepting edge latches the item and enters ST_EXEC, and leaving ST_EXEC
// updates the row and presents the response on rsp_o for one cycle with
// result_valid_o high. Delete-all stays in ST_EXEC while a match is left: the
// row drops one match per cycle, shifting every cell from the first match on.
// busy is low again in the cycle that shows the response, so a new item may be
// taken there. Responses cannot be held off: rsp_o is valid for that one cycle
// only. After reset the list is empty; entries hold no reset value and only
// entries below the fill count are ever used.
module bounded_byte_list_engine #(
  parameter int unsigned CAPACITY = bbl_pkg::BBL_CAPACITY
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  bbl_pkg::bbl_req_t req_i,
  output logic              result_valid_o,
  output bbl_pkg::bbl_rsp_t rsp_o
);
  import bbl_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  bbl_state_e       state_q, state_d;
  bbl_req_t         req_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] removed_q, removed_d;
  bbl_rsp_t         rsp_q, rsp_d;
  logic             valid_q;

  logic             accept;
  logic             finish;
  bbl_cell_cmd_e    cell_cmd;
  logic [IDX_W-1:0] ins_pos;
  logic [7:0]       cell_data [CAPACITY];
  logic [CAPACITY:0] seen;
  logic             any_hit;

  assign accept  = start && (state_q == ST_IDLE);
  assign busy    = (state_q != ST_IDLE);
  assign any_hit = seen[CAPACITY];
  assign seen[0] = 1'b0;

  // Row of list cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [7:0] left_data;
    logic [7:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = req_q.value;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
    end

    bbl_cell #(
      .INDEX (i),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cell_cmd),
      .ins_pos_i    (ins_pos),
      .count_i      (count_q),
      .value_i      (req_q.value),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .seen_i       (seen[i]),
      .seen_o       (seen[i+1]),
      .data_o       (cell_data[i])
    );
  end

  // Advance the controller
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Decode the request into a cell command, new counts and the response
  always_comb begin
    finish    = 1'b0;
    cell_cmd  = CELL_HOLD;
    ins_pos   = '0;
    count_d   = count_q;
    removed_d = removed_q;
    rsp_d     = rsp_q;

    if (state_q == ST_EXEC) begin
      finish           = 1'b1;
      rsp_d.status     = STAT_OK;
      rsp_d.found      = 1'b0;
      rsp_d.located_value = '0;
      removed_d        = '0;
      case (req_q.req_type)
        OP_INS_FIRST, OP_INS_MIDDLE, OP_INS_LAST: begin
          if (count_q >= CNT_W'(CAPACITY)) begin
            rsp_d.status = STAT_FULL;
          end else begin
            cell_cmd = CELL_INSERT;
            count_d  = count_q + 1'b1;
            if (req_q.req_type == OP_INS_FIRST) begin
              ins_pos = '0;
            end else if (req_q.req_type == OP_INS_MIDDLE) begin
              ins_pos = IDX_W'(count_q >> 1);
            end else begin
              ins_pos = IDX_W'(count_q);
            end
          end
        end
        OP_DEL_FIRST: begin
          if (count_q == '0) begin
            rsp_d.status = STAT_EMPTY;
          end else if (any_hit) begin
            cell_cmd  = CELL_REMOVE;
            count_d   = count_q - 1'b1;
            removed_d = CNT_W'(1);
          end else begin
            rsp_d.status = STAT_NOT_FOUND;
          end
        end
        OP_DEL_ALL: begin
          // drop one match per cycle until none is left
          if ((count_q == '0) && (removed_q == '0)) begin
            rsp_d.status = STAT_EMPTY;
          end else if (any_hit) begin
            finish    = 1'b0;
            cell_cmd  = CELL_REMOVE;
            count_d   = count_q - 1'b1;
            removed_d = removed_q + 1'b1;
          end else begin
            removed_d = removed_q;
          end
        end
        OP_DEL_LAST: begin
          if (count_q == '0) begin
            rsp_d.status = STAT_EMPTY;
          end else begin
            count_d   = count_q - 1'b1;
            removed_d = CNT_W'(1);
          end
        end
        OP_CLEAR: begin
          count_d   = '0;
          removed_d = count_q;
        end
        OP_QUERY: begin
          rsp_d.found         = any_hit;
          rsp_d.located_value = any_hit ? req_q.value : 8'h00;
        end
        default: begin
          rsp_d.status = STAT_OK;
        end
      endcase
      rsp_d.removed_count = BBL_CNT_OUT_W'(removed_d);
      rsp_d.item_count    = BBL_CNT_OUT_W'(count_d);
    end else if (accept) begin
      removed_d = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      removed_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      removed_q <= removed_d;
      valid_q   <= (state_q == ST_EXEC) && finish;
    end
  end

  // Hold the request and response payloads
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

  // Fill count stays within capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // An accepted item makes the engine busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted item did not start execution");

  // A response reports the fill count that the list now holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (rsp_o.item_count == BBL_CNT_OUT_W'(count_q)))
    else $error("response item count differs from fill count");

  // A response only follows execution
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_EXEC))
    else $error("response without execution");

endmodule

// ===== rtl/bbl_cell.sv =====
// ----------------------------------------------------------------------------
// bbl_cell
// One list entry. Compares its byte against the request value, passes the
// running "match seen" flag to its right neighbor, and on insert loads the request
// value or its left neighbor's byte, or on removal its right neighbor's byte.
// ----------------------------------------------------------------------------
module bbl_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned IDX_W = 4,
  parameter int unsigned CNT_W = 5
) (
  input  logic                   clk_i,
  input  bbl_pkg::bbl_cell_cmd_e cmd_i,
  input  logic [IDX_W-1:0]       ins_pos_i,
  input  logic [CNT_W-1:0]       count_i,
  input  logic [7:0]             value_i,
  input  logic [7:0]             left_data_i,
  input  logic [7:0]             right_data_i,
  input  logic                   seen_i,
  output logic                   seen_o,
  output logic [7:0]             data_o
);
  import bbl_pkg::*;

  logic [7:0] data_q, data_d;
  logic       occupied;
  logic       hit;

  // Match only entries below the fill count
  assign occupied = (count_i > CNT_W'(INDEX));
  assign hit      = occupied && (data_q == value_i);
  assign seen_o   = seen_i | hit;
  assign data_o   = data_q;

  // Select the next byte of this entry
  always_comb begin
    data_d = data_q;
    case (cmd_i)
      CELL_INSERT: begin
        if (ins_pos_i == IDX_W'(INDEX)) begin
          data_d = value_i;
        end else if (IDX_W'(INDEX) > ins_pos_i) begin
          data_d = left_data_i;
        end
      end
      CELL_REMOVE: begin
        if (seen_o) begin
          data_d = right_data_i;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  // Hold the entry byte
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule
